// ----- rtl/versioned_key_value_lookup_top_macros.svh -----
// Assertion macros for the versioned key-value lookup block.
// Included by the RTL file that carries concurrent checks (vkv_ctrl); no other dependencies.
`ifndef VERSIONED_KEY_VALUE_LOOKUP_TOP_MACROS_SVH
`define VERSIONED_KEY_VALUE_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VKV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VKV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vkv_pkg.sv -----
// Shared types and constants of the versioned key-value lookup block.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package vkv_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int TS_W        = 31;
    localparam int ENTRIES_DEF = 256;

    typedef enum logic
    {
        CMD_SET = 1'b0,
        CMD_GET = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic [TS_W-1:0]  ts;
        logic [VAL_W-1:0] value;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed
    {
        logic             full;
        logic [VAL_W-1:0] value;
        logic             found;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/vkv_table.sv -----
// Entry storage: one write port, one registered read port.
// Depends on vkv_pkg for the entry layout.
`default_nettype none

module vkv_table
#(
    parameter int ENTRIES = vkv_pkg::ENTRIES_DEF,
    parameter int AW      = $clog2(ENTRIES)
)
(
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire vkv_pkg::entry_t wr_entry,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output vkv_pkg::entry_t      rd_entry
);
    import vkv_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

// ----- rtl/vkv_ctrl.sv -----
// Sequencer with the shared key/time compare unit; owns the entry count.
// Depends on vkv_pkg and the assertion macro header.
`default_nettype none
`include "versioned_key_value_lookup_top_macros.svh"

module vkv_ctrl
#(
    parameter int ENTRIES = vkv_pkg::ENTRIES_DEF,
    parameter int AW      = $clog2(ENTRIES),
    parameter int CW      = $clog2(ENTRIES + 1)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output      logic            in_ready,
    input  wire vkv_pkg::cmd_t   in_cmd,
    input  wire vkv_pkg::entry_t in_entry,
    input  wire logic            out_free,
    output      logic            done,
    output vkv_pkg::result_t     res,
    output      logic            wr_en,
    output      logic [AW-1:0]   wr_addr,
    output vkv_pkg::entry_t      wr_entry,
    output      logic            rd_en,
    output      logic [AW-1:0]   rd_addr,
    input  wire vkv_pkg::entry_t rd_entry
);
    import vkv_pkg::*;

    state_t           state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic             pend_reg, pend_next;
    logic             last_reg, last_next;
    logic [KEY_W-1:0] qkey_reg, qkey_next;
    logic [TS_W-1:0]  qts_reg, qts_next;
    result_t          res_reg, res_next;
    logic             hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        qkey_reg <= qkey_next;
        qts_reg  <= qts_next;
        res_reg  <= res_next;
    end

    // Compare unit: one stored entry per cycle against the held query.
    assign hit = pend_reg && (rd_entry.key == qkey_reg) && (rd_entry.ts <= qts_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        pend_next  = pend_reg;
        last_next  = last_reg;
        qkey_next  = qkey_reg;
        qts_next   = qts_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        done       = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                    if (in_cmd == CMD_SET)
                    begin
                        if (cnt_reg == CW'(ENTRIES))
                        begin
                            res_next.full = 1'b1;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        qkey_next = in_entry.key;
                        qts_next  = in_entry.ts;
                        pend_next = 1'b0;
                        last_next = 1'b0;
                        if (cnt_reg != '0)
                        begin
                            addr_next  = AW'(cnt_reg - CW'(1));
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.found = 1'b1;
                    res_next.value = rd_entry.value;
                    state_next     = ST_DONE;
                end
                else if (pend_reg && last_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // Issue the next older entry while the previous one is compared.
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    last_next = (addr_reg == '0);
                    addr_next = addr_reg - AW'(1);
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res      = res_reg;
    assign wr_addr  = cnt_reg[AW-1:0];
    assign wr_entry = in_entry;
    assign rd_addr  = addr_reg;

    `VKV_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(ENTRIES), "count overflow")
    `VKV_ASSERT_NXT(a_cnt_step, clk, rst_n, wr_en, cnt_reg == $past(cnt_reg) + CW'(1), "count stuck")
    `VKV_ASSERT_IMP(a_rd_written, clk, rst_n, rd_en, CW'(rd_addr) < cnt_reg, "unwritten read")
    `VKV_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")

endmodule

`default_nettype wire

// ----- rtl/versioned_key_value_lookup_top.sv -----
// Top level of the versioned key-value lookup block: stream ports, output register.
// Depends on vkv_pkg, vkv_ctrl and vkv_table.
//
// Usage:
//   One command word enters on the s_axis channel; tuser[0] selects set (0) or
//   get (1). A set appends key, value and timestamp at the next free slot, or is
//   refused with full_res = 1 when all ENTRIES slots hold data. A get returns the
//   value of the newest stored entry with the same key and a timestamp not above
//   the query time, or found = 0 and a zero value when there is none.
//   Every command answers with exactly one word on the m_axis channel.
//
// Timing:
//   A set, or a get on an empty table, goes straight to the done state; once the
//   output register is free, the answer enters it and raises m_axis_tvalid. A get
//   walks the table from the newest entry down, one entry per cycle through the
//   registered read port, and stops early on a hit. The next word is taken only
//   after the answer has entered the output register.
// Reset clears the entry count, the state and the output valid flag; stored entries are not cleared.
// When the receiver stalls, the answer holds in the output register; the block
// still accepts one more word and then holds it finished until the register frees.
`default_nettype none

module versioned_key_value_lookup_top
#(
    parameter int ENTRIES = vkv_pkg::ENTRIES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // key[31:0], value[63:32], timestamp[94:64], zero
    input  wire logic [0:0]  s_axis_tuser,   // cmd[0]
    // Answer stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // result_value[31:0]
    output      logic [1:0]  m_axis_tuser    // found[0], full_res[1]
);
    import vkv_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    entry_t        in_entry;
    cmd_t          in_cmd;
    result_t       res;
    logic          done;
    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_entry;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_entry;

    logic          out_valid_reg, out_valid_next;
    result_t       out_res_reg, out_res_next;

    // Unpack the command word; the top pad bit of tdata is dropped.
    assign in_entry.key   = s_axis_tdata[31:0];
    assign in_entry.value = s_axis_tdata[63:32];
    assign in_entry.ts    = s_axis_tdata[94:64];
    assign in_cmd         = cmd_t'(s_axis_tuser[0]);

    vkv_ctrl
    #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .CW      (CW)
    )
    u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .in_entry (in_entry),
        .out_free (out_free),
        .done     (done),
        .res      (res),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    vkv_table
    #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    )
    u_table
    (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    // Output register: free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (done)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_res_reg.value;
    assign m_axis_tuser[0] = out_res_reg.found;
    assign m_axis_tuser[1] = out_res_reg.full;

endmodule

`default_nettype wire
